// File: hw/rtl/indexed_chipset_regs_shadow_decode_unit_macros.svh
// Assertion macros for the index/data register block.
`ifndef INDEXED_CHIPSET_REGS_SHADOW_DECODE_UNIT_MACROS_SVH
`define INDEXED_CHIPSET_REGS_SHADOW_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ICRSD_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ICRSD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: hw/rtl/icrsd_pkg.sv
// Types, constants and lookup functions shared by the register block modules.
`default_nettype none

package icrsd_pkg;

   localparam int CFG_COUNT = 14;

   // Access port codes.
   localparam logic [1:0] PORT_INDEX    = 2'd0;
   localparam logic [1:0] PORT_DATA     = 2'd1;
   localparam logic [1:0] PORT_SCRATCH0 = 2'd2;
   localparam logic [1:0] PORT_SCRATCH1 = 2'd3;

   // Register indexes and offsets into the configuration array.
   localparam logic [7:0] CFG_FIRST  = 8'h20;
   localparam logic [7:0] CFG_LAST   = 8'h2d;
   localparam logic [7:0] CFG_HOLE   = 8'h2c;
   localparam logic [7:0] IDX_REG20  = 8'h20;
   localparam logic [7:0] IDX_REG25  = 8'h25;
   localparam logic [7:0] IDX_REG2A  = 8'h2a;
   localparam logic [7:0] IDX_AFTER_DATA = 8'hff;
   localparam logic [7:0] FORCE_2A   = 8'h04;

   localparam logic [3:0] OFS_REG20 = 4'd0;
   localparam logic [3:0] OFS_REG21 = 4'd1;
   localparam logic [3:0] OFS_REG22 = 4'd2;
   localparam logic [3:0] OFS_REG23 = 4'd3;
   localparam logic [3:0] OFS_REG25 = 4'd5;
   localparam logic [3:0] OFS_REG26 = 4'd6;
   localparam logic [3:0] OFS_REG2D = 4'd13;

   localparam logic [7:0] READ_IDLE  = 8'hff;
   localparam logic [7:0] WRITE_READ = 8'h00;
   localparam logic [7:0] SCRATCH_RESET = 8'hff;

   // Attribute codes: bits 3:2 write target, bits 1:0 read source.
   localparam logic [3:0] ATTR_INT_INT = 4'h0;
   localparam logic [3:0] ATTR_EXT_EXT = 4'h5;
   localparam logic [3:0] ATTR_ANY_ANY = 4'ha;
   localparam logic [3:0] ATTR_INT_OFF = 4'hc;
   localparam logic [3:0] ATTR_ANY_INT = 4'h2;
   localparam logic [1:0] RD_EXT = 2'd1;
   localparam logic [1:0] RD_ANY = 2'd2;
   localparam logic [1:0] WR_INT = 2'd0;
   localparam logic [1:0] WR_OFF = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [1:0] port;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [3:0]  top_bios_attr;
      logic [31:0] de_segment_attrs;
      logic [15:0] c_segment_attrs;
      logic [3:0]  isa_divider;
      logic        isa_doubled;
      logic        halt_reset_enable;
      logic        ext_cache_enable;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   function automatic logic [7:0] cfg_reset_value(input logic [3:0] ofs);
      logic [7:0] val;
      case (ofs)
         4'd2:    val = 8'h84;
         4'd4:    val = 8'h87;
         4'd5:    val = 8'hf0;
         4'd7:    val = 8'hd1;
         4'd8:    val = 8'h80;
         4'd9:    val = 8'h10;
         4'd10:   val = 8'h80;
         4'd11:   val = 8'h10;
         4'd13:   val = 8'h40;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] cfg_write_mask(input logic [3:0] ofs);
      logic [7:0] val;
      case (ofs)
         4'd0:    val = 8'h3f;
         4'd4:    val = 8'hf7;
         4'd8:    val = 8'he3;
         4'd10:   val = 8'hfb;
         4'd12:   val = 8'h00;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

   function automatic logic [3:0] isa_div_lookup(input logic sel, input logic [1:0] code);
      logic [3:0] val;
      case ({sel, code})
         3'b000:  val = 4'd6;
         3'b001:  val = 4'd5;
         3'b010:  val = 4'd4;
         3'b011:  val = 4'd3;
         3'b100:  val = 4'd8;
         3'b101:  val = 4'd6;
         3'b110:  val = 4'd5;
         default: val = 4'd4;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/icrsd_ctrl.sv
// Sequencing state machine: accept, execute, present the result strobe.
`default_nettype none

module icrsd_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   output logic                rsp_valid,
   output icrsd_pkg::cmd_type  cmd
);

   icrsd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icrsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         icrsd_pkg::ST_IDLE: begin
            if (start) state_in = icrsd_pkg::ST_EXEC;
         end
         icrsd_pkg::ST_EXEC: begin
            state_in = icrsd_pkg::ST_RESP;
         end
         icrsd_pkg::ST_RESP: begin
            state_in = start ? icrsd_pkg::ST_EXEC : icrsd_pkg::ST_IDLE;
         end
         default: begin
            state_in = icrsd_pkg::ST_IDLE;
         end
      endcase
   end

   // A new transaction may be taken while the previous result is on the strobe.
   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         icrsd_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         icrsd_pkg::ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         icrsd_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/icrsd_datapath.sv
// Register file, access decode and shadow attribute decode.
`default_nettype none

module icrsd_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  icrsd_pkg::cmd_type  cmd,
   input  icrsd_pkg::req_type  req_data,
   output icrsd_pkg::rsp_type  rsp_data
);

   icrsd_pkg::req_type req_ff;
   icrsd_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] index_ff, index_in;
   logic [7:0] cfg_ff [icrsd_pkg::CFG_COUNT];
   logic [7:0] cfg_in [icrsd_pkg::CFG_COUNT];
   logic [7:0] scratch_ff [2];
   logic [7:0] scratch_in [2];
   logic       sel_ff, sel_in;

   logic       idx_valid;
   logic [3:0] idx_ofs;
   logic [7:0] wr_value;
   logic [7:0] rd_byte;

   assign idx_valid = (index_ff >= icrsd_pkg::CFG_FIRST) && (index_ff <= icrsd_pkg::CFG_LAST)
                      && (index_ff != icrsd_pkg::CFG_HOLE);
   assign idx_ofs   = 4'(index_ff - icrsd_pkg::CFG_FIRST);

   always_comb begin
      wr_value = req_ff.write_data & icrsd_pkg::cfg_write_mask(idx_ofs);
      if (index_ff == icrsd_pkg::IDX_REG2A) wr_value = wr_value | icrsd_pkg::FORCE_2A;
   end

   // Next register state for the transaction held in req_ff.
   always_comb begin
      index_in   = index_ff;
      cfg_in     = cfg_ff;
      scratch_in = scratch_ff;
      sel_in     = sel_ff;
      rd_byte    = req_ff.mode ? icrsd_pkg::WRITE_READ : icrsd_pkg::READ_IDLE;
      case (req_ff.port)
         icrsd_pkg::PORT_INDEX: begin
            if (req_ff.mode) index_in = req_ff.write_data;
         end
         icrsd_pkg::PORT_DATA: begin
            if (idx_valid) begin
               if (req_ff.mode) begin
                  cfg_in[idx_ofs] = wr_value;
                  if (index_ff == icrsd_pkg::IDX_REG20) sel_in = 1'b0;
                  else if (index_ff == icrsd_pkg::IDX_REG25) sel_in = 1'b1;
               end else begin
                  rd_byte = cfg_ff[idx_ofs];
               end
            end
            index_in = icrsd_pkg::IDX_AFTER_DATA;
         end
         icrsd_pkg::PORT_SCRATCH0, icrsd_pkg::PORT_SCRATCH1: begin
            if (req_ff.mode) scratch_in[req_ff.port[0]] = req_ff.write_data;
            else rd_byte = scratch_ff[req_ff.port[0]];
         end
         default: begin
            index_in = index_ff;
         end
      endcase
   end

   // Attribute decode from the updated registers.
   always_comb begin
      logic [7:0] r22, r23, r26, r2d;
      logic [1:0] wr_tgt;
      logic       en, wp, any_rd;
      logic [3:0] code;
      r22 = cfg_in[icrsd_pkg::OFS_REG22];
      r23 = cfg_in[icrsd_pkg::OFS_REG23];
      r26 = cfg_in[icrsd_pkg::OFS_REG26];
      r2d = cfg_in[icrsd_pkg::OFS_REG2D];
      rsp_in.read_data     = rd_byte;
      rsp_in.top_bios_attr = r22[7] ? icrsd_pkg::ATTR_ANY_INT : icrsd_pkg::ATTR_INT_OFF;
      rsp_in.de_segment_attrs = '0;
      for (int i = 0; i < 8; i++) begin
         en = (i >= 4) ? r22[5] : r22[6];
         wp = (i >= 4) ? r22[3] : r22[4];
         if (en && r23[i]) code = wp ? icrsd_pkg::ATTR_INT_OFF : icrsd_pkg::ATTR_INT_INT;
         else code = r2d[(i >> 1) + 2] ? icrsd_pkg::ATTR_ANY_ANY : icrsd_pkg::ATTR_EXT_EXT;
         rsp_in.de_segment_attrs[4*i +: 4] = code;
      end
      wr_tgt = r26[5] ? icrsd_pkg::WR_OFF : icrsd_pkg::WR_INT;
      rsp_in.c_segment_attrs = '0;
      for (int i = 0; i < 4; i++) begin
         any_rd = r2d[i >> 1];
         if (r26[4] && r26[i]) code = {wr_tgt, 2'b00};
         else if (r26[6]) code = {wr_tgt, any_rd ? icrsd_pkg::RD_ANY : icrsd_pkg::RD_EXT};
         else code = any_rd ? icrsd_pkg::ATTR_ANY_ANY : icrsd_pkg::ATTR_EXT_EXT;
         rsp_in.c_segment_attrs[4*i +: 4] = code;
      end
      rsp_in.isa_divider = icrsd_pkg::isa_div_lookup(sel_in,
                                                      cfg_in[icrsd_pkg::OFS_REG25][1:0]);
      rsp_in.isa_doubled       = ~cfg_in[icrsd_pkg::OFS_REG20][4];
      rsp_in.halt_reset_enable = ~cfg_in[icrsd_pkg::OFS_REG20][1];
      rsp_in.ext_cache_enable  = cfg_in[icrsd_pkg::OFS_REG21][4];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         sel_ff   <= 1'b0;
         for (int k = 0; k < icrsd_pkg::CFG_COUNT; k++) begin
            cfg_ff[k] <= icrsd_pkg::cfg_reset_value(4'(k));
         end
         scratch_ff[0] <= icrsd_pkg::SCRATCH_RESET;
         scratch_ff[1] <= icrsd_pkg::SCRATCH_RESET;
      end else if (cmd.exec) begin
         index_ff   <= index_in;
         sel_ff     <= sel_in;
         cfg_ff     <= cfg_in;
         scratch_ff <= scratch_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_chipset_regs_shadow_decode_unit.sv
// Index/data chipset register block with shadow region decode (top level).
// The accepting edge enters the execute step; the result strobe is high in the response state after it.
// The controller's execute step holds off the next transaction.
// busy is high only in the execute cycle; a new start may coincide with the strobe.
// The receiver cannot stall, so a result never holds off the next transaction.
// Synchronous reset restores the index, configuration defaults and scratch bytes.
`default_nettype none

`include "indexed_chipset_regs_shadow_decode_unit_macros.svh"

module indexed_chipset_regs_shadow_decode_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  icrsd_pkg::req_type  req_data,
   output logic                rsp_valid,
   output icrsd_pkg::rsp_type  rsp_data
);

   icrsd_pkg::cmd_type cmd;
   logic               div_ok;

   icrsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   icrsd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign div_ok = (rsp_data.isa_divider >= 4'd3) && (rsp_data.isa_divider <= 4'd8);

   `ICRSD_ASSERT_NEXT(a_accept_executes, clock, reset, start && !busy, busy, "no execute step")
   `ICRSD_ASSERT_NEXT(a_exec_responds, clock, reset, busy, rsp_valid && !busy, "no result strobe")
   `ICRSD_ASSERT_NOW(a_div_range, clock, reset, rsp_valid, div_ok, "ISA divider out of range")

endmodule

`default_nettype wire
